>>> sv/apsp_pkg.sv
package apsp_pkg;

  localparam int MAX_VERTICES_DEF = 16;

  localparam int ACTION_W = 2;
  localparam int VERTEX_W = 4;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 32;
  localparam int VCOUNT_W = 5;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

  localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RUN  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;

  localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7fff_ffff;
  localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

endpackage

>>> sv/apsp_if.sv
interface apsp_item_if;
  import apsp_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic [VERTEX_W-1:0]        row;
  logic [VERTEX_W-1:0]        col;
  logic signed [WEIGHT_W-1:0] weight;

  modport source (output valid, action, row, col, weight, input ready);
  modport sink   (input valid, action, row, col, weight, output ready);
endinterface

interface apsp_result_if;
  import apsp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DIST_W-1:0] distance;
  logic [VERTEX_W-1:0]      via_vertex;
  logic                     has_via;
  logic                     read_valid;

  modport source (output valid, distance, via_vertex, has_via, read_valid, input ready);
  modport sink   (input valid, distance, via_vertex, has_via, read_valid, output ready);
endinterface

>>> sv/all_pairs_shortest_path.sv
// all-pairs shortest path engine (floyd-warshall on a dense weight matrix)
// item channel: action load writes one edge weight, run computes all pairs
// over the first vertex_count vertices, read returns length and via vertex
// of one pair. every item answers with exactly one transfer on the result
// channel; read_valid marks read answers, load and run give acknowledgements.
// cfg_we/cfg_data write vertex_count (clamped to MAX_VERTICES when used);
// write it only while idle; the block itself does not enforce this.
// load and read pass through LOAD or RDMEM on their way to FINISH;
// unknown actions and a run with vertex_count 0 go straight to FINISH.
// a run copies the weights into the path-length memory, then does one
// saturating add and compare per vertex triple on that memory, which gives
// two reads and one write per cycle, after a row setup (ROW, DIK) per row.
// items are taken one at a time; ready is high only when idle, so a new
// item is taken only once the last result has entered the output register.
// reset clears the control state and sets vertex_count to 16; the weight,
// length and via memories are not cleared and must be written first.
// when the receiver stalls the result stays in the output register; the
// next item is still taken, and its result waits until the register frees.
module all_pairs_shortest_path #(
  parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [apsp_pkg::VCOUNT_W-1:0] cfg_data,
  apsp_item_if.sink                     item,
  apsp_result_if.source                 result
);
  import apsp_pkg::*;

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int AW    = $clog2(MAX_VERTICES * MAX_VERTICES);
  localparam int NW    = $clog2(MAX_VERTICES + 1);
  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_LOAD   = 8'b0000_0010,
    ST_RDMEM  = 8'b0000_0100,
    ST_COPY   = 8'b0000_1000,
    ST_ROW    = 8'b0001_0000,
    ST_DIK    = 8'b0010_0000,
    ST_SWEEP  = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_t;

  function automatic logic [AW-1:0] pair_addr(input int r, input int c);
    return AW'(r * MAX_VERTICES + c);
  endfunction

  state_t state;

  logic [VCOUNT_W-1:0]        vcount;
  logic [ACTION_W-1:0]        act;
  logic [AW-1:0]              addr;
  logic                       in_range;
  logic signed [WEIGHT_W-1:0] weight;

  logic [VW-1:0] i;
  logic [VW-1:0] j;
  logic [VW-1:0] k;
  logic [NW-1:0] n;
  logic          last_i;
  logic          last_j;
  logic          last_k;
  logic          item_in_range;
  logic          drained;

  logic signed [WEIGHT_W-1:0] edge_mem [DEPTH];
  logic signed [DIST_W-1:0]   path_mem [DEPTH];
  logic [VERTEX_W:0]          mid_mem  [DEPTH];

  logic signed [WEIGHT_W-1:0] edge_rd;
  logic signed [DIST_W-1:0]   rd_a;
  logic signed [DIST_W-1:0]   rd_b;
  logic [VERTEX_W:0]          mid_rd;

  logic                     edge_we;
  logic                     edge_re;
  logic [AW-1:0]            edge_raddr;
  logic                     path_we;
  logic [AW-1:0]            path_waddr;
  logic signed [DIST_W-1:0] path_wdata;
  logic [VERTEX_W:0]        mid_wdata;
  logic                     re_a;
  logic                     re_b;
  logic [AW-1:0]            raddr_a;
  logic [AW-1:0]            raddr_b;

  // copy stage
  logic          cp_valid;
  logic [AW-1:0] cp_addr;

  // relax stage
  logic                     rx_valid;
  logic [AW-1:0]            rx_addr;
  logic                     rx_dik_hit;
  logic [VERTEX_W-1:0]      rx_via;
  logic signed [DIST_W-1:0] dik;
  logic signed [DIST_W:0]   wide;
  logic signed [DIST_W-1:0] sum;
  logic                     improve;

  logic                     out_valid;
  logic signed [DIST_W-1:0] out_distance;
  logic [VERTEX_W-1:0]      out_via;
  logic                     out_has_via;
  logic                     out_read_valid;
  logic                     out_free;

  always_comb begin
    n = (int'(vcount) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vcount);
  end

  assign last_i        = (NW'(i) == n - NW'(1));
  assign last_j        = (NW'(j) == n - NW'(1));
  assign last_k        = (NW'(k) == n - NW'(1));
  assign item_in_range = (int'(item.row) < MAX_VERTICES) && (int'(item.col) < MAX_VERTICES);
  assign drained       = !cp_valid && !rx_valid;
  assign out_free      = !out_valid || result.ready;

  assign item.ready = (state == ST_IDLE);

  // saturating leg sum and compare
  assign wide    = (DIST_W + 1)'(dik) + (DIST_W + 1)'(rd_a);
  assign sum     = (wide[DIST_W] != wide[DIST_W-1]) ?
                   (wide[DIST_W] ? DIST_MIN : DIST_MAX) : wide[DIST_W-1:0];
  assign improve = rx_valid && (sum < rd_b);

  // memory port control
  assign edge_we    = (state == ST_LOAD) && in_range;
  assign edge_re    = (state == ST_COPY);
  assign edge_raddr = pair_addr(int'(i), int'(j));

  always_comb begin
    path_we    = 1'b0;
    path_waddr = rx_addr;
    path_wdata = sum;
    mid_wdata  = {1'b1, rx_via};
    if (cp_valid) begin
      path_we    = 1'b1;
      path_waddr = cp_addr;
      path_wdata = DIST_W'(edge_rd);
      mid_wdata  = '0;
    end else if (improve) begin
      path_we = 1'b1;
    end
  end

  always_comb begin
    re_a    = 1'b0;
    re_b    = 1'b0;
    raddr_a = addr;
    raddr_b = pair_addr(int'(i), int'(j));
    case (state)
      ST_RDMEM: begin
        re_a = 1'b1;
      end
      ST_ROW: begin
        re_a    = drained;
        raddr_a = pair_addr(int'(i), int'(k));
      end
      ST_SWEEP: begin
        re_a    = 1'b1;
        re_b    = 1'b1;
        raddr_a = pair_addr(int'(k), int'(j));
      end
      default: begin
        re_a = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[addr] <= weight;
    end
    if (edge_re) begin
      edge_rd <= edge_mem[edge_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (path_we) begin
      path_mem[path_waddr] <= path_wdata;
      mid_mem[path_waddr]  <= mid_wdata;
    end
    if (re_a) begin
      rd_a <= path_mem[raddr_a];
    end
    if (re_b) begin
      rd_b <= path_mem[raddr_b];
    end
    if (state == ST_RDMEM) begin
      mid_rd <= mid_mem[addr];
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    cp_addr    <= edge_raddr;
    rx_addr    <= raddr_b;
    rx_dik_hit <= (j == k);
    rx_via     <= VERTEX_W'(k);
    if (state == ST_DIK) begin
      dik <= rd_a;
    end else if (improve && rx_dik_hit) begin
      dik <= sum;
    end
    if (state == ST_IDLE && item.valid) begin
      act      <= item.action;
      in_range <= item_in_range;
      addr     <= item_in_range ? pair_addr(int'(item.row), int'(item.col)) : '0;
      weight   <= item.weight;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= VCOUNT_RESET;
    end else if (cfg_we) begin
      vcount <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      cp_valid  <= 1'b0;
      rx_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cp_valid <= (state == ST_COPY);
      rx_valid <= (state == ST_SWEEP);
      if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item.valid) begin
            i <= '0;
            j <= '0;
            k <= '0;
            if (item.action == ACT_LOAD) begin
              state <= ST_LOAD;
            end else if (item.action == ACT_READ) begin
              state <= ST_RDMEM;
            end else if (item.action == ACT_RUN && n != '0) begin
              state <= ST_COPY;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_LOAD: begin
          state <= ST_FINISH;
        end
        ST_RDMEM: begin
          state <= ST_FINISH;
        end
        ST_COPY: begin
          if (last_j) begin
            j <= '0;
            if (last_i) begin
              i     <= '0;
              state <= ST_ROW;
            end else begin
              i <= i + VW'(1);
            end
          end else begin
            j <= j + VW'(1);
          end
        end
        ST_ROW: begin
          if (drained) begin
            state <= ST_DIK;
          end
        end
        ST_DIK: begin
          j     <= '0;
          state <= ST_SWEEP;
        end
        ST_SWEEP: begin
          if (last_j) begin
            j <= '0;
            if (last_i) begin
              i <= '0;
              if (last_k) begin
                state <= ST_FINISH;
              end else begin
                k     <= k + VW'(1);
                state <= ST_ROW;
              end
            end else begin
              i     <= i + VW'(1);
              state <= ST_ROW;
            end
          end else begin
            j <= j + VW'(1);
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      out_read_valid <= (act == ACT_READ);
      out_distance   <= (act == ACT_READ && in_range) ? rd_a : '0;
      out_has_via    <= (act == ACT_READ) && in_range && mid_rd[VERTEX_W];
      out_via        <= ((act == ACT_READ) && in_range && mid_rd[VERTEX_W]) ?
                        mid_rd[VERTEX_W-1:0] : '0;
    end
  end

  assign result.valid      = out_valid;
  assign result.distance   = out_distance;
  assign result.via_vertex = out_via;
  assign result.has_via    = out_has_via;
  assign result.read_valid = out_read_valid;

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(cp_valid && rx_valid))
    else $error("copy and relax stages write together");

  a_row_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIK) |-> ($past(state) == ST_ROW && $past(drained)))
    else $error("row setup read issued with a pending write");

  a_relax_origin: assert property (@(posedge clk) disable iff (rst)
    rx_valid |-> ($past(state) == ST_SWEEP))
    else $error("relax stage active outside a sweep");

  a_hold_finish: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_valid && !result.ready) |=> (state == ST_FINISH))
    else $error("result register overwritten while stalled");

endmodule
